/* src/ble_pkg.sv */
// ----------------------------------------------------------------------------
// ble_pkg
// Shared types, constants and the discharge curve of the battery level
// estimator.
// ----------------------------------------------------------------------------
package ble_pkg;

	localparam int SAMPLE_W     = 12;
	localparam int MV_W         = 14;
	localparam int PCT_W        = 7;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 14;
	localparam int CURVE_MV_W   = 13;
	localparam int CURVE_POINTS = 13;
	localparam int SEG_W        = 4;
	localparam int PCT_NUM_W    = 12;
	localparam int ADC_FS_MV    = 3300;
	localparam int ADC_BITS     = 12;
	localparam int CONV_W       = SAMPLE_W + ADC_BITS;

	localparam int DEF_SAMPLES_PER_READ = 8;
	localparam int DEF_DIVIDER_RATIO    = 3;

	localparam logic [MV_W-1:0]       MV_MAX         = 14'd16383;
	localparam logic [MV_W-1:0]       USB_THRESH_RST = 14'd4350;
	localparam logic [PCT_W-1:0]      PCT_FULL       = 7'd100;
	localparam logic [PCT_W-1:0]      PCT_EMPTY      = 7'd0;

	localparam logic [CFG_IDX_W-1:0] REG_INPUT_IS_RAW = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_USB_THRESH   = 1'd1;

	localparam logic [CURVE_MV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
		13'd4150, 13'd4080, 13'd4000, 13'd3900, 13'd3850, 13'd3800, 13'd3750,
		13'd3700, 13'd3650, 13'd3600, 13'd3500, 13'd3400, 13'd3300
	};
	localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
		7'd100, 7'd92, 7'd84, 7'd70, 7'd62, 7'd54, 7'd46,
		7'd38, 7'd29, 7'd20, 7'd10, 7'd5, 7'd0
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_AVG,
		ST_AVG_WAIT,
		ST_SEG,
		ST_PCT,
		ST_PCT_WAIT,
		ST_OUT
	} ble_state_t;

endpackage

/* src/ble_divider.sv */
// ----------------------------------------------------------------------------
// ble_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ble_divider #(
	parameter int W = 20
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output logic         busy,
	output logic [W-1:0] quo
);

	localparam int CNT_W = $clog2(W + 1);

	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [W:0]       shifted;
	logic [W:0]       diff;

	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

/* src/battery_level_estimator_core.sv */
// ----------------------------------------------------------------------------
// battery_level_estimator_core
// Averages bursts of ADC samples and maps the result to a charge percent.
// ----------------------------------------------------------------------------
// Each accepted sample is captured, then converted and accumulated, before
// the next is accepted. The last sample of a burst starts the result
// sequence: up to two divisions on one shared restoring divider, one quotient
// bit per cycle, DIV_W bits wide (at least the width of DIVIDER_RATIO times
// the largest burst sum; 17 bits at the defaults). Results at or beyond the
// ends of the curve skip the second division. A finished result sits in the
// output register while the next burst is accepted.
// ----------------------------------------------------------------------------
module battery_level_estimator_core import ble_pkg::*; #(
	parameter int SAMPLES_PER_READ = DEF_SAMPLES_PER_READ,
	parameter int DIVIDER_RATIO    = DEF_DIVIDER_RATIO
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [15:0]           s_axis_tdata,  // [11:0] sample
	input  logic                  s_axis_tuser,  // [0] sample_ok
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [23:0]           m_axis_tdata,  // [13:0] system_mv, [20:14] percent, [21] on_usb
	output logic                  m_axis_tuser   // [0] read_ok
);

	localparam int MAX_SAMPLE = (2 ** SAMPLE_W) - 1;
	localparam int SUM_W      = $clog2(SAMPLES_PER_READ * MAX_SAMPLE + 1);
	localparam int CNT_W      = $clog2(SAMPLES_PER_READ + 1);
	localparam int NUM_W      = $clog2(DIVIDER_RATIO * SAMPLES_PER_READ * MAX_SAMPLE + 1);
	localparam int DIV_A      = (NUM_W > PCT_NUM_W) ? NUM_W : PCT_NUM_W;
	localparam int DIV_W      = (DIV_A > MV_W) ? DIV_A : MV_W;

	ble_state_t state_q, state_d;

	logic                  raw_q;
	logic [MV_W-1:0]       thresh_q;
	logic [SAMPLE_W-1:0]   sample_q;
	logic                  ok_q;
	logic [CNT_W-1:0]      pos_q;
	logic [SUM_W-1:0]      sum_q;
	logic [CNT_W-1:0]      good_q;
	logic [MV_W-1:0]       sys_q;
	logic [PCT_W-1:0]      pct_q;
	logic                  rok_q;
	logic [SEG_W-1:0]      seg_q;
	logic                  out_valid_q;
	logic [MV_W-1:0]       out_mv_q;
	logic [PCT_W-1:0]      out_pct_q;
	logic                  out_usb_q;
	logic                  out_rok_q;

	logic [CONV_W-1:0]     conv_prod;
	logic [SAMPLE_W-1:0]   mv_in;
	logic                  last_sample;
	logic                  out_free;
	logic [SEG_W-1:0]      seg_d;
	logic [CURVE_MV_W-1:0] seg_lo;
	logic [CURVE_MV_W-1:0] seg_span;
	logic [PCT_W-1:0]      seg_dpct;
	logic [PCT_NUM_W-1:0]  pct_num;
	logic                  div_start;
	logic [DIV_W-1:0]      div_num;
	logic [DIV_W-1:0]      div_den;
	logic                  div_busy;
	logic [DIV_W-1:0]      div_quo;

	assign conv_prod   = CONV_W'(sample_q) * CONV_W'(ADC_FS_MV);
	assign mv_in       = raw_q ? conv_prod[CONV_W-1:ADC_BITS] : sample_q;
	assign last_sample = (pos_q + 1'b1) == CNT_W'(SAMPLES_PER_READ);
	assign out_free    = !out_valid_q || m_axis_tready;

	// lowest-index curve point at or below the voltage
	always_comb begin
		seg_d = SEG_W'(CURVE_POINTS - 1);
		for (int i = CURVE_POINTS - 1; i >= 1; i--) begin
			if ({1'b0, sys_q} >= (MV_W + 1)'(CURVE_MV[i])) begin
				seg_d = SEG_W'(i);
			end
		end
	end

	assign seg_lo   = CURVE_MV[seg_q];
	assign seg_span = CURVE_MV[SEG_W'(seg_q - 1'b1)] - seg_lo;
	assign seg_dpct = CURVE_PCT[SEG_W'(seg_q - 1'b1)] - CURVE_PCT[seg_q];
	assign pct_num  = ((PCT_NUM_W'(sys_q) - PCT_NUM_W'(seg_lo)) * PCT_NUM_W'(seg_dpct)
		* PCT_NUM_W'(2)) + PCT_NUM_W'(seg_span);

	always_comb begin
		if (state_q == ST_AVG) begin
			div_num = DIV_W'(NUM_W'(DIVIDER_RATIO) * NUM_W'(sum_q));
			div_den = DIV_W'(good_q);
		end else begin
			div_num = DIV_W'(pct_num);
			div_den = DIV_W'({seg_span, 1'b0});
		end
	end

	ble_divider #(
		.W(DIV_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) state_d = ST_ACC;
			end
			ST_ACC: begin
				state_d = last_sample ? ST_AVG : ST_IDLE;
			end
			ST_AVG: begin
				if (good_q == '0) begin
					state_d = ST_OUT;
				end else begin
					div_start = 1'b1;
					state_d   = ST_AVG_WAIT;
				end
			end
			ST_AVG_WAIT: begin
				if (!div_busy) state_d = ST_SEG;
			end
			ST_SEG: begin
				if ({1'b0, sys_q} >= (MV_W + 1)'(CURVE_MV[0]) ||
				    {1'b0, sys_q} <= (MV_W + 1)'(CURVE_MV[CURVE_POINTS - 1])) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_PCT;
				end
			end
			ST_PCT: begin
				div_start = 1'b1;
				state_d   = ST_PCT_WAIT;
			end
			ST_PCT_WAIT: begin
				if (!div_busy) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q    <= 1'b0;
			thresh_q <= USB_THRESH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INPUT_IS_RAW: raw_q    <= cfg_wdata[0];
				REG_USB_THRESH:   thresh_q <= cfg_wdata[MV_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			sum_q  <= '0;
			good_q <= '0;
		end else if (state_q == ST_ACC) begin
			pos_q <= pos_q + 1'b1;
			if (ok_q) begin
				sum_q  <= sum_q + SUM_W'(mv_in);
				good_q <= good_q + 1'b1;
			end
		end else if (state_q == ST_OUT && out_free) begin
			pos_q  <= '0;
			sum_q  <= '0;
			good_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				sample_q <= s_axis_tdata[SAMPLE_W-1:0];
				ok_q     <= s_axis_tuser;
			end
			ST_AVG: begin
				rok_q <= 1'b0;
				sys_q <= '0;
				pct_q <= PCT_EMPTY;
			end
			ST_AVG_WAIT: begin
				rok_q <= 1'b1;
				sys_q <= (div_quo > DIV_W'(MV_MAX)) ? MV_MAX : div_quo[MV_W-1:0];
			end
			ST_SEG: begin
				seg_q <= seg_d;
				pct_q <= ({1'b0, sys_q} >= (MV_W + 1)'(CURVE_MV[0])) ? PCT_FULL : PCT_EMPTY;
			end
			ST_PCT_WAIT: begin
				pct_q <= CURVE_PCT[seg_q] + div_quo[PCT_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			out_rok_q <= rok_q;
			out_mv_q  <= sys_q;
			out_pct_q <= pct_q;
			out_usb_q <= rok_q && (sys_q >= thresh_q);
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_usb_q, out_pct_q, out_mv_q};
	assign m_axis_tuser  = out_rok_q;

endmodule
